// ===== hdl/gsa_pkg.sv =====
package gsa_pkg;

  localparam int SLOTS     = 64;
  localparam int PRODUCERS = 4;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GEN_W     = 7;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [1:0] K_ALLOC   = 2'd0;
  localparam logic [1:0] K_UPDATE  = 2'd1;
  localparam logic [1:0] K_RELEASE = 2'd2;
  localparam logic [1:0] K_RESOLVE = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_SEALED = 3'd1;
  localparam logic [2:0] ST_UNBOUND    = 3'd2;
  localparam logic [2:0] ST_BAD_STATE  = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_STALE      = 3'd5;

  localparam logic CFG_BOUND_MASK = 1'b0;
  localparam logic CFG_SEALED     = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  producer;
    logic [15:0] reference_in;
    logic [31:0] record_payload;
    logic        state_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] reference_out;
    logic [1:0]  producer_out;
    logic [31:0] payload_out;
    logic [31:0] revision;
    logic [6:0]  alive_count;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        producer;
    logic [SLOT_W-1:0] slot;
    logic              range_ok;
    logic [7:0]        gen_in;
    logic [31:0]       payload;
    logic              state_ok;
    logic [2:0]        pre_status;
  } cmd_t;

endpackage

// ===== hdl/generational_slot_allocator_top.sv =====
// Generational slot allocator: a pool of 64 slots, each with a 7-bit generation,
// a producer and a 32-bit payload. Items allocate the lowest free slot, update,
// release or resolve a handle (slot*256+generation); every item gives exactly one
// result with a status, the handle and stored data on success, the revision count
// and the number of live slots. The front checks the allocate preconditions and
// queues up to two items; the back handles each item as a slot pick and
// registered slot-memory read, then a check and write-back, and takes no new
// item until the last one has committed; a held result stalls the write-back.
// The result register lets the front keep accepting while a result is held.
// No clearing pass after reset.
module generational_slot_allocator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  gsa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gsa_pkg::out_t out_data,
  input  logic          cfg_write_en,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data
);
  import gsa_pkg::*;

  logic [3:0] bound_mask;
  logic       sealed;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_mask <= '0;
      sealed     <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BOUND_MASK: bound_mask <= cfg_data;
        CFG_SEALED:     sealed     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gsa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .bound_mask (bound_mask),
    .sealed     (sealed),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data)
  );

  gsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.reference_out == '0) && (out_data.producer_out == '0) &&
      (out_data.payload_out == '0))
    else $error("error result carries slot data");

  a_alive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_data.alive_count} <= 8'(SLOTS)))
    else $error("live count above pool size");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status <= ST_STALE))
    else $error("undefined status code");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ===== hdl/gsa_front.sv =====
module gsa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  gsa_pkg::in_t   in_data,
  input  logic [3:0]     bound_mask,
  input  logic           sealed,
  output logic           q_valid,
  input  logic           q_pop,
  output gsa_pkg::cmd_t  q_data
);
  import gsa_pkg::*;

  cmd_t              fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cls;
  logic              push;
  logic              prod_bound;

  always_comb begin
    prod_bound = ({3'b000, in_data.producer} < 5'(PRODUCERS)) &&
                 bound_mask[in_data.producer];
    cls.kind     = in_data.kind;
    cls.producer = in_data.producer;
    cls.slot     = in_data.reference_in[8 +: SLOT_W];
    cls.range_ok = {1'b0, in_data.reference_in[15:8]} < 9'(SLOTS);
    cls.gen_in   = in_data.reference_in[7:0];
    cls.payload  = in_data.record_payload;
    cls.state_ok = in_data.state_ok;
    // allocate checks that need no slot state
    if (!sealed) begin
      cls.pre_status = ST_NOT_SEALED;
    end else if (!prod_bound) begin
      cls.pre_status = ST_UNBOUND;
    end else if (!in_data.state_ok) begin
      cls.pre_status = ST_BAD_STATE;
    end else begin
      cls.pre_status = ST_OK;
    end
  end

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_data   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

endmodule

// ===== hdl/gsa_back.sv =====
module gsa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  gsa_pkg::cmd_t  q_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gsa_pkg::out_t  out_data
);
  import gsa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state;
  cmd_t              cmd;
  cmd_t              cmd_in;
  logic              full;
  logic [SLOTS-1:0]  in_use;
  logic [SLOTS-1:0]  gen_vld;
  logic [GEN_W-1:0]  gen_mem  [SLOTS];
  logic [1:0]        prod_mem [SLOTS];
  logic [31:0]       pay_mem  [SLOTS];
  logic [GEN_W-1:0]  gen_rd;
  logic              gen_vld_rd;
  logic [1:0]        prod_rd;
  logic [31:0]       pay_rd;
  logic [31:0]       revision;
  logic [6:0]        alive;

  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] slot_sel;
  logic              commit;
  logic [GEN_W-1:0]  gen_cur;
  logic [GEN_W-1:0]  gen_out;
  logic              live;
  logic [2:0]        status;
  logic              alloc_we;
  logic              pay_we;
  logic              rel_we;
  logic              bump;
  logic [1:0]        prod_o;
  logic [31:0]       pay_o;
  logic [15:0]       handle;
  logic [31:0]       revision_next;
  logic [6:0]        alive_next;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign slot_sel = (q_data.kind == K_ALLOC) ? free_idx : q_data.slot;
  assign commit   = (state == S_EXEC) && (!out_valid || !out_stall);
  assign gen_cur  = gen_vld_rd ? gen_rd : '0;

  always_comb begin
    cmd_in      = q_data;
    cmd_in.slot = slot_sel;
  end

  always_comb begin
    status   = ST_OK;
    alloc_we = 1'b0;
    pay_we   = 1'b0;
    rel_we   = 1'b0;
    bump     = 1'b0;
    gen_out  = gen_cur;
    prod_o   = prod_rd;
    pay_o    = pay_rd;
    live     = cmd.range_ok && in_use[cmd.slot] && ({1'b0, gen_cur} == cmd.gen_in);
    case (cmd.kind)
      K_ALLOC: begin
        prod_o = cmd.producer;
        pay_o  = cmd.payload;
        if (cmd.pre_status != ST_OK) begin
          status = cmd.pre_status;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          alloc_we = 1'b1;
          bump     = 1'b1;
          gen_out  = gen_cur + 1'b1;
        end
      end
      K_UPDATE: begin
        pay_o = cmd.payload;
        if (!live) begin
          status = ST_STALE;
        end else if (!cmd.state_ok) begin
          status = ST_BAD_STATE;
        end else begin
          pay_we = 1'b1;
          bump   = 1'b1;
        end
      end
      K_RELEASE: begin
        if (!live) begin
          status = ST_STALE;
        end else begin
          rel_we = 1'b1;
          bump   = 1'b1;
        end
      end
      default: begin
        if (!live) begin
          status = ST_STALE;
        end
      end
    endcase
    handle        = {8'(cmd.slot), 1'b0, gen_out};
    revision_next = revision + 32'(bump);
    alive_next    = alive + 7'(alloc_we) - 7'(rel_we);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      gen_vld   <= '0;
      revision  <= '0;
      alive     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        revision <= revision_next;
        alive    <= alive_next;
        if (alloc_we) begin
          in_use[cmd.slot]  <= 1'b1;
          gen_vld[cmd.slot] <= 1'b1;
        end
        if (rel_we) begin
          in_use[cmd.slot] <= 1'b0;
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item register, slot memories with registered read
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd        <= cmd_in;
      full       <= &in_use;
      gen_rd     <= gen_mem[slot_sel];
      prod_rd    <= prod_mem[slot_sel];
      pay_rd     <= pay_mem[slot_sel];
      gen_vld_rd <= gen_vld[slot_sel];
    end
    if (commit && alloc_we) begin
      gen_mem[cmd.slot]  <= gen_out;
      prod_mem[cmd.slot] <= cmd.producer;
    end
    if (commit && (alloc_we || pay_we)) begin
      pay_mem[cmd.slot] <= cmd.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.status      <= status;
      out_data.revision    <= revision_next;
      out_data.alive_count <= alive_next;
      if (status == ST_OK) begin
        out_data.reference_out <= handle[13:0];
        out_data.producer_out  <= prod_o;
        out_data.payload_out   <= pay_o;
      end else begin
        out_data.reference_out <= '0;
        out_data.producer_out  <= '0;
        out_data.payload_out   <= '0;
      end
    end
  end

endmodule
